// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Working variables of the compression function.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	// Control from the sequencer to the block buffer.
	typedef struct packed {
		logic       byte_en;
		logic [7:0] byte_val;
		logic       word_en;
	} sched_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} pad_phase_t;

	localparam logic       KIND_DATA   = 1'b0;
	localparam logic       KIND_FINISH = 1'b1;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [7:0] PAD_ZERO    = 8'h00;
	localparam logic [5:0] LEN_POS     = 6'd56;
	localparam logic [5:0] FILL_LAST   = 6'd63;
	localparam logic [6:0] ROUND_LAST  = 7'd79;
	localparam logic [2:0] WORD_LAST   = 3'd4;
	localparam logic [63:0] LEN_STEP   = 64'd8;

endpackage

// ===== rtl/core/sha1_round.sv =====
module sha1_round (
	input  sha1_pkg::work_t    cur,
	input  logic [6:0]         round,
	input  logic [31:0]        w,
	output sha1_pkg::work_t    nxt
);
	import sha1_pkg::*;

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;

	always_comb begin
		if (round < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_0;
		end else if (round < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_1;
		end else if (round < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_3;
		end
		t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

// ===== rtl/core/sha1_sched.sv =====
module sha1_sched (
	input  logic                 clk,
	input  sha1_pkg::sched_ctl_t ctl,
	output logic [31:0]          w
);
	import sha1_pkg::*;

	// The 64-byte block sits in a 512-bit shift line. Bytes enter at the
	// low end; during compression the oldest word leaves at the top and the
	// next schedule word enters at the bottom, so the line is the 16-word
	// window of the message schedule.
	logic [511:0] buf_q;
	logic [31:0]  w_new;

	always_comb begin
		w_new = buf_q[511-32*0 -: 32] ^ buf_q[511-32*2 -: 32] ^
			buf_q[511-32*8 -: 32] ^ buf_q[511-32*13 -: 32];
		w = buf_q[511 -: 32];
	end

	always_ff @(posedge clk) begin
		if (ctl.byte_en) begin
			buf_q <= {buf_q[503:0], ctl.byte_val};
		end else if (ctl.word_en) begin
			buf_q <= {buf_q[479:0], w_new[30:0], w_new[31]};
		end
	end

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------
// item     | item_valid / item_ready    | kind, data_byte (sha1_pkg::in_item_t)
// digest   | digest_valid / digest_ready| digest_word, word_index, last_word
//
// A data byte is shifted into the block buffer as it is accepted; the byte
// that fills a block starts 80 rounds on the one round unit, then the
// chaining add. No bytes are taken meanwhile, so that unit sets the rate.
// A finish writes 9 to 72 padding bytes at one per cycle, pausing for one or two
// compressions, then offers the five digest words, one per accepted item.
// item_ready is high only while the hasher is idle; a stalled digest word
// holds. Reset is asynchronous and returns the initial hash values.
module sha1_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  sha1_pkg::in_item_t  item,
	output logic                digest_valid,
	input  logic                digest_ready,
	output sha1_pkg::out_item_t digest
);
	import sha1_pkg::*;

	state_t      state_q, state_d;
	pad_phase_t  phase_q, phase_d;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic        fin_q;
	logic [6:0]  round_q;
	logic [2:0]  idx_q;
	logic [31:0] chain_q [5];
	work_t       work_q;
	work_t       work_nxt;
	logic [31:0] w;
	sched_ctl_t  ctl;
	logic        start_comp;
	logic        fin_set;
	logic        len_add;
	logic        done;
	logic [7:0]  len_byte;

	sha1_sched u_sched (
		.clk (clk),
		.ctl (ctl),
		.w   (w)
	);

	sha1_round u_round (
		.cur   (work_q),
		.round (round_q),
		.w     (w),
		.nxt   (work_nxt)
	);

	// Length bytes occupy buffer positions 56..63, most significant first.
	assign len_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		item_ready   = 1'b0;
		digest_valid = 1'b0;
		ctl          = '0;
		start_comp   = 1'b0;
		fin_set      = 1'b0;
		len_add      = 1'b0;
		done         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.kind == KIND_DATA) begin
						ctl.byte_en  = 1'b1;
						ctl.byte_val = item.data_byte;
						len_add      = 1'b1;
						if (fill_q == FILL_LAST) begin
							start_comp = 1'b1;
							state_d    = ST_COMP;
						end
					end else begin
						fin_set = 1'b1;
						phase_d = PH_MARK;
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				ctl.byte_en = 1'b1;
				case (phase_q)
					PH_MARK: begin
						ctl.byte_val = PAD_MARK;
						phase_d      = PH_ZERO;
					end
					PH_ZERO: begin
						if (fill_q == LEN_POS) begin
							ctl.byte_val = len_byte;
							phase_d      = PH_LEN;
						end else begin
							ctl.byte_val = PAD_ZERO;
						end
					end
					default: begin
						ctl.byte_val = len_byte;
					end
				endcase
				if (fill_q == FILL_LAST) begin
					start_comp = 1'b1;
					state_d    = ST_COMP;
				end
			end
			ST_COMP: begin
				ctl.word_en = 1'b1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (fin_q && phase_q == PH_LEN) begin
					state_d = ST_OUT;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				digest_valid = 1'b1;
				if (digest_ready && idx_q == WORD_LAST) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARK;
			fill_q  <= '0;
			len_q   <= '0;
			fin_q   <= 1'b0;
			round_q <= '0;
			idx_q   <= '0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			phase_q <= phase_d;
			if (ctl.byte_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (len_add) begin
				len_q <= len_q + LEN_STEP;
			end
			if (fin_set) begin
				fin_q <= 1'b1;
			end
			if (start_comp) begin
				round_q <= '0;
			end else if (state_q == ST_COMP) begin
				round_q <= round_q + 7'd1;
			end
			if (state_q == ST_FINAL) begin
				chain_q[0] <= chain_q[0] + work_q.a;
				chain_q[1] <= chain_q[1] + work_q.b;
				chain_q[2] <= chain_q[2] + work_q.c;
				chain_q[3] <= chain_q[3] + work_q.d;
				chain_q[4] <= chain_q[4] + work_q.e;
			end
			if (done) begin
				idx_q <= '0;
			end else if (digest_valid && digest_ready) begin
				idx_q <= idx_q + 3'd1;
			end
			if (done) begin
				fin_q <= 1'b0;
				len_q <= '0;
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= H_INIT[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_comp) begin
			work_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
		end else if (state_q == ST_COMP) begin
			work_q <= work_nxt;
		end
	end

	always_comb begin
		digest.digest_word = chain_q[idx_q];
		digest.word_index  = idx_q;
		digest.last_word   = (idx_q == WORD_LAST);
	end

endmodule

// ===== rtl/core/sha1_chk.sv =====
module sha1_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input sha1_pkg::in_item_t  item,
	input logic                digest_valid,
	input logic                digest_ready,
	input sha1_pkg::out_item_t digest
);
	import sha1_pkg::*;

	// The hasher never takes an item while it offers a digest word.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && digest_valid))
		else $error("item_ready and digest_valid both high");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest))
		else $error("stalled digest word changed");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !digest.last_word |=>
			digest_valid && digest.word_index == $past(digest.word_index) + 3'd1)
		else $error("digest words out of order");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && digest.last_word |=> !digest_valid && item_ready)
		else $error("hasher not idle after last digest word");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> digest.last_word == (digest.word_index == WORD_LAST))
		else $error("last_word does not match word_index");

endmodule

bind sha1_stream_hasher sha1_chk u_chk (.*);

// ===== tb/tb_sha1_stream_hasher.sv =====
module tb_sha1_stream_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1_pkg::*;

	localparam int          STALL_LIMIT = 3000;
	localparam int          PHASE_ITEMS = 85;
	localparam int          TAIL_CYCLES = 100;
	localparam logic [7:0]  MARK_BYTE   = 8'h80;
	localparam int          LEN_OFFSET  = 56;
	localparam logic [31:0] RK_0        = 32'h5a827999;
	localparam logic [31:0] RK_1        = 32'h6ed9eba1;
	localparam logic [31:0] RK_2        = 32'h8f1bbcdc;
	localparam logic [31:0] RK_3        = 32'hca62c1d6;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      digest_valid;
	logic      digest_ready = 1'b0;
	out_item_t digest;

	sha1_stream_hasher DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hash state of the predictor.
	logic [31:0] hash_h [5];
	logic [7:0]  msg_buf [64];
	int          msg_fill;
	logic [63:0] msg_bits;

	out_item_t   digest_q [$];
	int          errors = 0;
	int          items_sent = 0;
	int          messages_done = 0;
	int          words_checked = 0;
	int          stall_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	function automatic logic [31:0] rol(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void sha1_clear();
		hash_h[0] = 32'h67452301;
		hash_h[1] = 32'hefcdab89;
		hash_h[2] = 32'h98badcfe;
		hash_h[3] = 32'h10325476;
		hash_h[4] = 32'hc3d2e1f0;
		for (int i = 0; i < 64; i++)
			msg_buf[i] = 8'h00;
		msg_fill = 0;
		msg_bits = '0;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_h[0];
		b = hash_h[1];
		c = hash_h[2];
		d = hash_h[3];
		e = hash_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = RK_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = RK_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RK_2;
			end else begin
				f = b ^ c ^ d;
				k = RK_3;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		hash_h[0] += a;
		hash_h[1] += b;
		hash_h[2] += c;
		hash_h[3] += d;
		hash_h[4] += e;
	endfunction

	// A block is compressed the moment its last byte lands.
	function automatic void sha1_absorb(input logic [7:0] v);
		msg_buf[msg_fill] = v;
		msg_fill++;
		if (msg_fill == 64) begin
			sha1_compress();
			msg_fill = 0;
		end
	endfunction

	function automatic void sha1_model_step(input in_item_t it);
		logic [63:0] len;
		out_item_t   w;
		if (it.kind == KIND_DATA) begin
			msg_bits += 64'd8;
			sha1_absorb(it.data_byte);
		end else begin
			len = msg_bits;
			sha1_absorb(MARK_BYTE);
			while (msg_fill != LEN_OFFSET)
				sha1_absorb(8'h00);
			for (int j = 0; j < 8; j++)
				sha1_absorb(len[63 - 8*j -: 8]);
			for (int j = 0; j < 5; j++) begin
				w.digest_word = hash_h[j];
				w.word_index = 3'(j);
				w.last_word = (j == 4);
				digest_q.push_back(w);
			end
			sha1_clear();
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		errors++;
	endtask

	// Valid is dropped only for idle gaps and while draining, so back-to-back items keep it high.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		sha1_model_step(it);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] v);
		in_item_t it;
		it.kind = KIND_DATA;
		it.data_byte = v;
		send_item(it);
	endtask

	task automatic send_finish();
		in_item_t it;
		it.kind = KIND_FINISH;
		it.data_byte = 8'($urandom_range(255));
		send_item(it);
		messages_done++;
	endtask

	task automatic hold_until_drained();
		item_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_message();
		send_finish();
	endtask

	task automatic test_short_messages();
		send_byte(8'h61);
		send_byte(8'h62);
		send_byte(8'h63);
		send_finish();
		send_byte(8'h00);
		send_finish();
		send_byte(8'hff);
		send_finish();
		send_byte(8'h55);
		send_byte(8'haa);
		send_finish();
	endtask

	// A finish right after a finish hashes the empty message again.
	task automatic test_back_to_back_finish();
		send_byte(8'h5a);
		send_finish();
		send_finish();
	endtask

	task automatic test_random_messages(input int sidle, input int ridle);
		int start;
		int len;
		start = items_sent;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		while (items_sent - start < PHASE_ITEMS) begin
			// Lengths near the padding boundaries force one or two final blocks.
			case ($urandom_range(9))
				0: len = LEN_OFFSET - 1 + $urandom_range(2);
				1: len = 63 + $urandom_range(2);
				2: len = 119 + $urandom_range(9);
				3: len = $urandom_range(3);
				default: len = $urandom_range(1, 48);
			endcase
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom));
			send_finish();
		end
		hold_until_drained();
	endtask

	always @(posedge clk) begin
		out_item_t exp_w;
		if (arst_n) begin
			if ((item_valid && item_ready) || (digest_valid && digest_ready))
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
				$display("sha1_stream_hasher: mismatch");
				$finish;
			end
			if (digest_valid && digest_ready) begin
				words_checked++;
				if (digest_q.size() == 0) begin
					report_mismatch($sformatf("unexpected digest word %h", digest.digest_word));
				end else begin
					exp_w = digest_q.pop_front();
					if (digest.digest_word !== exp_w.digest_word)
						report_mismatch($sformatf("word %0d: digest_word %h, expected %h",
							exp_w.word_index, digest.digest_word, exp_w.digest_word));
					if (digest.word_index !== exp_w.word_index)
						report_mismatch($sformatf("word_index %0d, expected %0d",
							digest.word_index, exp_w.word_index));
					if (digest.last_word !== exp_w.last_word)
						report_mismatch($sformatf("word %0d: last_word %b, expected %b",
							exp_w.word_index, digest.last_word, exp_w.last_word));
				end
			end
		end
		digest_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		sha1_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_short_messages();
		test_back_to_back_finish();
		hold_until_drained();

		test_random_messages(29, 65);
		test_random_messages(65, 29);
		test_random_messages(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (digest_q.size() != 0)
			report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));

		$display("Hashed %0d messages from %0d items, including empty ones and lengths at",
			messages_done, items_sent);
		$display("the padding edges; %0d digest words checked under three pacing mixes.",
			words_checked);
		if (errors == 0) begin
			$display("sha1_stream_hasher: match");
		end else begin
			$display("sha1_stream_hasher: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sha1_pkg.sv
rtl/core/sha1_round.sv
rtl/core/sha1_sched.sv
rtl/core/sha1_stream_hasher.sv
rtl/core/sha1_chk.sv
tb/tb_sha1_stream_hasher.sv
